// ===== src/npe_pkg.sv =====
// Shared constants, microcode program and helper functions of the next permutation engine.
package npe_pkg;

   // Default sizes of the list store.
   localparam int MAX_LEN_DEF    = 64;
   localparam int VALUE_BITS_DEF = 16;

   // Microcode field widths.
   localparam int PC_W   = 4;
   localparam int OP_W   = 4;
   localparam int COND_W = 4;

   // Program steps, which double as jump targets.
   localparam logic [PC_W-1:0] S_LOAD     = 4'd0;
   localparam logic [PC_W-1:0] S_P_INIT   = 4'd1;
   localparam logic [PC_W-1:0] S_P_PRIME  = 4'd2;
   localparam logic [PC_W-1:0] S_P_LOOP   = 4'd3;
   localparam logic [PC_W-1:0] S_WRAP     = 4'd4;
   localparam logic [PC_W-1:0] S_F_INIT   = 4'd5;
   localparam logic [PC_W-1:0] S_F_LOOP   = 4'd6;
   localparam logic [PC_W-1:0] S_SWAP_PIV = 4'd7;
   localparam logic [PC_W-1:0] S_SWAP_Q   = 4'd8;
   localparam logic [PC_W-1:0] S_R_TEST   = 4'd9;
   localparam logic [PC_W-1:0] S_R_RD_HI  = 4'd10;
   localparam logic [PC_W-1:0] S_R_WR_LO  = 4'd11;
   localparam logic [PC_W-1:0] S_R_WR_HI  = 4'd12;
   localparam logic [PC_W-1:0] S_E_INIT   = 4'd13;
   localparam logic [PC_W-1:0] S_EMIT     = 4'd14;
   localparam logic [PC_W-1:0] S_DONE     = 4'd15;

   // Datapath operations.
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd0;
   localparam logic [OP_W-1:0] OP_P_INIT   = 4'd1;
   localparam logic [OP_W-1:0] OP_P_STEP   = 4'd2;
   localparam logic [OP_W-1:0] OP_P_LOOP   = 4'd3;
   localparam logic [OP_W-1:0] OP_WRAP     = 4'd4;
   localparam logic [OP_W-1:0] OP_F_INIT   = 4'd5;
   localparam logic [OP_W-1:0] OP_F_LOOP   = 4'd6;
   localparam logic [OP_W-1:0] OP_SWAP_PIV = 4'd7;
   localparam logic [OP_W-1:0] OP_SWAP_Q   = 4'd8;
   localparam logic [OP_W-1:0] OP_R_RD_LO  = 4'd9;
   localparam logic [OP_W-1:0] OP_R_RD_HI  = 4'd10;
   localparam logic [OP_W-1:0] OP_R_WR_LO  = 4'd11;
   localparam logic [OP_W-1:0] OP_R_WR_HI  = 4'd12;
   localparam logic [OP_W-1:0] OP_E_INIT   = 4'd13;
   localparam logic [OP_W-1:0] OP_EMIT     = 4'd14;
   localparam logic [OP_W-1:0] OP_CLEAR    = 4'd15;

   // Jump conditions.
   localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
   localparam logic [COND_W-1:0] C_LAST_XFER = 4'd2;
   localparam logic [COND_W-1:0] C_ONE       = 4'd3;
   localparam logic [COND_W-1:0] C_LT        = 4'd4;
   localparam logic [COND_W-1:0] C_SCAN_NZ   = 4'd5;
   localparam logic [COND_W-1:0] C_NOT_GT    = 4'd6;
   localparam logic [COND_W-1:0] C_LO_GE_HI  = 4'd7;
   localparam logic [COND_W-1:0] C_EMIT_HOLD = 4'd8;

   // One control word: an operation and two prioritized conditional jumps.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond_a;
      logic [PC_W-1:0]   tgt_a;
      logic [COND_W-1:0] cond_b;
      logic [PC_W-1:0]   tgt_b;
   } ucode_type;

   // Status flags that the datapath reports to the sequencer.
   typedef struct packed {
      logic last_xfer;
      logic one;
      logic lt;
      logic scan_nz;
      logic not_gt;
      logic lo_ge_hi;
      logic emit_hold;
   } cond_flags_type;

   // The control program. With no jump taken the step counter advances by one.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         S_LOAD:     w = '{OP_LOAD,     C_LAST_XFER, S_P_INIT, C_ALWAYS,  S_LOAD};
         S_P_INIT:   w = '{OP_P_INIT,   C_ONE,       S_WRAP,   C_NEVER,   S_LOAD};
         S_P_PRIME:  w = '{OP_P_STEP,   C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_P_LOOP:   w = '{OP_P_LOOP,   C_LT,        S_F_INIT, C_SCAN_NZ, S_P_LOOP};
         S_WRAP:     w = '{OP_WRAP,     C_ALWAYS,    S_R_TEST, C_NEVER,   S_LOAD};
         S_F_INIT:   w = '{OP_F_INIT,   C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_F_LOOP:   w = '{OP_F_LOOP,   C_NOT_GT,    S_F_LOOP, C_NEVER,   S_LOAD};
         S_SWAP_PIV: w = '{OP_SWAP_PIV, C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_SWAP_Q:   w = '{OP_SWAP_Q,   C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_R_TEST:   w = '{OP_R_RD_LO,  C_LO_GE_HI,  S_E_INIT, C_NEVER,   S_LOAD};
         S_R_RD_HI:  w = '{OP_R_RD_HI,  C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_R_WR_LO:  w = '{OP_R_WR_LO,  C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_R_WR_HI:  w = '{OP_R_WR_HI,  C_ALWAYS,    S_R_TEST, C_NEVER,   S_LOAD};
         S_E_INIT:   w = '{OP_E_INIT,   C_NEVER,     S_LOAD,   C_NEVER,   S_LOAD};
         S_EMIT:     w = '{OP_EMIT,     C_EMIT_HOLD, S_EMIT,   C_NEVER,   S_LOAD};
         S_DONE:     w = '{OP_CLEAR,    C_ALWAYS,    S_LOAD,   C_NEVER,   S_LOAD};
         default:    w = '{OP_CLEAR,    C_ALWAYS,    S_LOAD,   C_NEVER,   S_LOAD};
      endcase
      return w;
   endfunction

   // Evaluates one jump condition against the datapath flags.
   function automatic logic cond_hit(input logic [COND_W-1:0] code,
                                     input cond_flags_type    flags);
      logic hit;
      unique case (code)
         C_NEVER:     hit = 1'b0;
         C_ALWAYS:    hit = 1'b1;
         C_LAST_XFER: hit = flags.last_xfer;
         C_ONE:       hit = flags.one;
         C_LT:        hit = flags.lt;
         C_SCAN_NZ:   hit = flags.scan_nz;
         C_NOT_GT:    hit = flags.not_gt;
         C_LO_GE_HI:  hit = flags.lo_ge_hi;
         C_EMIT_HOLD: hit = flags.emit_hold;
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ===== src/npe_if.sv =====
// Valid/ready channel interfaces for list elements in and permuted elements out.
interface npe_req_if #(
   parameter int VALUE_BITS = npe_pkg::VALUE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface npe_rsp_if #(
   parameter int VALUE_BITS = npe_pkg::VALUE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value_res;
   logic                  is_last_res;
   logic                  wrapped;
   logic                  truncated;

   modport source (output valid, output value_res, output is_last_res,
                   output wrapped, output truncated, input ready);
   modport sink   (input valid, input value_res, input is_last_res,
                   input wrapped, input truncated, output ready);
endinterface

// ===== src/npe_ram.sv =====
// Element store: one write port and one registered read port.
module npe_ram #(
   parameter int DEPTH  = npe_pkg::MAX_LEN_DEF,
   parameter int WIDTH  = npe_pkg::VALUE_BITS_DEF,
   parameter int ADDR_W = $clog2(npe_pkg::MAX_LEN_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/next_permutation_engine_top.sv =====
// Top level: microcoded sequencer and datapath that permute a loaded list.
//
//   Channel    Direction  Payload                                     Transfer when
//   req_chan   in         value, is_last                              valid && ready
//   rsp_chan   out        value_res, is_last_res, wrapped, truncated  valid && ready
//
// Loading accepts one element per cycle; ready is high only while the sequencer loads.
// After the last element of a list the pivot scan runs, then either the successor
// scan and the swap or, with no pivot, the wrap set-up; the reversal and the emission
// follow. The reversal tests, reads the high element, writes the low one and writes
// the high one per swapped pair. The single read port serialises these steps.
// The output register lets the next list load while the final result still waits.
// Reset is synchronous and needs no clearing pass; a stalled result channel holds the
// emit step.
module next_permutation_engine_top #(
   parameter int MAX_LEN    = npe_pkg::MAX_LEN_DEF,
   parameter int VALUE_BITS = npe_pkg::VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   npe_req_if.sink    req_chan,
   npe_rsp_if.source  rsp_chan
);

   import npe_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   // Sequencer and control registers.
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic                  wrap_ff, wrap_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      pivot_ff, pivot_in;
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic [VALUE_BITS-1:0] hold_ff, hold_in;
   logic [VALUE_BITS-1:0] pval_ff, pval_in;
   logic [VALUE_BITS-1:0] qval_ff, qval_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_wrap_ff, rsp_wrap_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;

   // Store ports.
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   ucode_type             uword;
   cond_flags_type        flags;
   logic [IDX_W-1:0]      n_m1;
   logic                  out_free;
   logic                  last_elem;

   npe_ram #(
      .DEPTH  (MAX_LEN),
      .WIDTH  (VALUE_BITS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control word fetch and status flags.
   assign uword     = ucode_rom(pc_ff);
   assign n_m1      = IDX_W'(cnt_ff - CNT_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_elem = (scan_ff == n_m1);

   assign flags.last_xfer = req_chan.valid && req_chan.is_last;
   assign flags.one       = (cnt_ff == CNT_W'(1));
   assign flags.lt        = (rd_data < hold_ff);
   assign flags.scan_nz   = (scan_ff != '0);
   assign flags.not_gt    = !(rd_data > pval_ff);
   assign flags.lo_ge_hi  = (lo_ff >= hi_ff);
   assign flags.emit_hold = !out_free || !last_elem;

   // Next step: the first jump wins, otherwise fall through.
   always_comb begin
      if (cond_hit(uword.cond_a, flags)) begin
         pc_in = uword.tgt_a;
      end else if (cond_hit(uword.cond_b, flags)) begin
         pc_in = uword.tgt_b;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // Datapath decode of the current operation.
   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      wrap_in      = wrap_ff;
      scan_in      = scan_ff;
      pivot_in     = pivot_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hold_in      = hold_ff;
      pval_in      = pval_ff;
      qval_in      = qval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      rsp_trunc_in = rsp_trunc_ff;
      wr_en        = 1'b0;
      wr_addr      = lo_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = scan_ff;

      unique case (uword.op) inside
         OP_LOAD: begin
            // Store the element while room is left, else note the loss.
            if (req_chan.valid) begin
               if (cnt_ff < CNT_W'(MAX_LEN)) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(cnt_ff);
                  wr_data = req_chan.value;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         OP_P_INIT, OP_F_INIT: begin
            rd_en   = 1'b1;
            rd_addr = n_m1;
            scan_in = n_m1;
         end
         OP_P_STEP: begin
            hold_in = rd_data;
            rd_en   = 1'b1;
            rd_addr = scan_ff - IDX_W'(1);
            scan_in = scan_ff - IDX_W'(1);
         end
         OP_P_LOOP: begin
            // Pivot is the first element from the right below its successor.
            if (flags.lt) begin
               pivot_in = scan_ff;
               pval_in  = rd_data;
            end else if (flags.scan_nz) begin
               hold_in = rd_data;
               rd_en   = 1'b1;
               rd_addr = scan_ff - IDX_W'(1);
               scan_in = scan_ff - IDX_W'(1);
            end
         end
         OP_WRAP: begin
            lo_in   = '0;
            hi_in   = n_m1;
            wrap_in = 1'b1;
         end
         OP_F_LOOP: begin
            // Rightmost element larger than the pivot.
            if (flags.not_gt) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff - IDX_W'(1);
               scan_in = scan_ff - IDX_W'(1);
            end else begin
               qval_in = rd_data;
            end
         end
         OP_SWAP_PIV: begin
            wr_en   = 1'b1;
            wr_addr = pivot_ff;
            wr_data = qval_ff;
         end
         OP_SWAP_Q: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = pval_ff;
            lo_in   = pivot_ff + IDX_W'(1);
            hi_in   = n_m1;
         end
         OP_R_RD_LO: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff;
         end
         OP_R_RD_HI: begin
            hold_in = rd_data;
            rd_en   = 1'b1;
            rd_addr = hi_ff;
         end
         OP_R_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
         end
         OP_R_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = hold_ff;
            lo_in   = lo_ff + IDX_W'(1);
            hi_in   = hi_ff - IDX_W'(1);
         end
         OP_E_INIT: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            scan_in = '0;
         end
         OP_EMIT: begin
            // Move one element to the output register when it is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data;
               rsp_last_in  = last_elem;
               rsp_wrap_in  = wrap_ff;
               rsp_trunc_in = ovf_ff;
               if (!last_elem) begin
                  rd_en   = 1'b1;
                  rd_addr = scan_ff + IDX_W'(1);
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            cnt_in  = '0;
            ovf_in  = 1'b0;
            wrap_in = 1'b0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pivot_ff     <= pivot_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      hold_ff      <= hold_in;
      pval_ff      <= pval_in;
      qval_ff      <= qval_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_wrap_ff  <= rsp_wrap_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // Channel outputs.
   assign req_chan.ready       = (pc_ff == S_LOAD);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value_res   = rsp_value_ff;
   assign rsp_chan.is_last_res = rsp_last_ff;
   assign rsp_chan.wrapped     = rsp_wrap_ff;
   assign rsp_chan.truncated   = rsp_trunc_ff;

endmodule
